FILE: hdl/atacc_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the activity time accumulator
// no dependencies; imported by every module of the block

package atacc_pkg;

  // fixed-point constants, 1 g = 4096 counts
  localparam logic [16:0] ONE_G_COUNTS = 17'd4096;

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP_1000  = 32'h10624DD3;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned SECS_W      = 23;

  // configuration port
  localparam int unsigned ADDR_W      = 3;
  localparam logic        REG_MOVE_THR = 1'b0;
  localparam logic        REG_MAX_GAP  = 1'b1;
  localparam logic [16:0] THR_RESET    = 17'd410;
  localparam logic [15:0] GAP_RESET    = 16'd200;

  // square root iterations, two radicand bits each
  localparam int unsigned ROOT_STEPS = 16;
  localparam int unsigned STEP_W     = 4;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROOT_STEPS - 1);
  localparam logic [31:0] ROOT_TOP_BIT = 32'h4000_0000;

  // shared multiplier operand select
  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MUL_SQ_X = 2'd0;
  localparam mul_sel_t MUL_SQ_Y = 2'd1;
  localparam mul_sel_t MUL_SQ_Z = 2'd2;
  localparam mul_sel_t MUL_DIV  = 2'd3;

  typedef struct packed {
    logic [16:0] move_threshold;
    logic [15:0] max_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic              capture;
    logic              mul_en;
    mul_sel_t          mul_sel;
    logic              rad_load;
    logic              rad_add;
    logic              root_step;
    logic [STEP_W-1:0] step;
    logic              upd;
    logic              acc;
    logic              report;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
  } dp_stat_t;

  // magnitude of a 16-bit two's complement value, -32768 gives 32768
  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic [15:0] res;
    res = v[15] ? (16'd0 - 16'(v)) : 16'(v);
    return res;
  endfunction

endpackage

FILE: hdl/atacc_regs.sv
`timescale 1ns / 1ps
// apb register file: movement threshold and longest credited gap
// depends on atacc_pkg

module atacc_regs import atacc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [16:0] thr_r;
  logic [15:0] gap_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      gap_r <= GAP_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MOVE_THR: thr_r <= pwdata[16:0];
        REG_MAX_GAP:  gap_r <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MOVE_THR: prdata = {15'd0, thr_r};
      REG_MAX_GAP:  prdata = {16'd0, gap_r};
    endcase
  end

  assign cfg.move_threshold = thr_r;
  assign cfg.max_gap_ms     = gap_r;

endmodule

FILE: hdl/atacc_dp.sv
`timescale 1ns / 1ps
// datapath: shared multiplier, iterative square root, counters and snapshot registers
// depends on atacc_pkg; driven by atacc_ctrl commands

module atacc_dp import atacc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  cfg_t               cfg,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic [31:0]        in_now_ms,
  output dp_stat_t           stat,
  output logic [31:0]        out_total_samples,
  output logic [31:0]        out_active_time_ms,
  output logic [16:0]        out_peak_deviation
);

  // captured beat
  logic [15:0] ax_r, ay_r, az_r;
  logic [31:0] now_r;

  // work registers
  logic [63:0] prod_r;
  logic [31:0] rad_r;
  logic [31:0] root_r;
  logic [16:0] dev_r;
  logic [31:0] gap_r;

  // persistent state
  logic [31:0]       cnt_r;
  logic [31:0]       act_r;
  logic [16:0]       peak_r;
  logic [31:0]       prev_r;
  logic [SECS_W-1:0] rep_r;

  // snapshot
  logic [31:0] o_cnt_r, o_act_r;
  logic [16:0] o_peak_r;

  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod_nxt;
  logic [31:0]       bit_val, trial;
  logic              fits;
  logic [16:0]       mag, dev;
  logic [32:0]       act_sum;
  logic              credit;
  logic [SECS_W-1:0] secs;

  always_comb begin
    case (cmd.mul_sel)
      MUL_SQ_X: begin mul_a = {16'd0, ax_r}; mul_b = {16'd0, ax_r}; end
      MUL_SQ_Y: begin mul_a = {16'd0, ay_r}; mul_b = {16'd0, ay_r}; end
      MUL_SQ_Z: begin mul_a = {16'd0, az_r}; mul_b = {16'd0, az_r}; end
      MUL_DIV:  begin mul_a = act_r;         mul_b = RECIP_1000;    end
    endcase
  end

  assign prod_nxt = 64'(mul_a) * 64'(mul_b);

  // one result bit per step, bit weight 4^(15-step)
  assign bit_val = ROOT_TOP_BIT >> {cmd.step, 1'b0};
  assign trial   = root_r + bit_val;
  assign fits    = (rad_r >= trial);

  assign mag = root_r[16:0];
  assign dev = (mag >= ONE_G_COUNTS) ? (mag - ONE_G_COUNTS) : (ONE_G_COUNTS - mag);

  assign act_sum = {1'b0, act_r} + {1'b0, gap_r};
  assign credit  = (dev_r > cfg.move_threshold) && (gap_r != 32'd0)
                   && (gap_r <= {16'd0, cfg.max_gap_ms});

  assign secs = prod_r[RECIP_SHIFT+SECS_W-1:RECIP_SHIFT];
  assign stat.emit = (secs != rep_r) || (cnt_r == 32'd1);

  // work, capture and snapshot registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ax_r  <= abs16(in_accel_x);
      ay_r  <= abs16(in_accel_y);
      az_r  <= abs16(in_accel_z);
      now_r <= in_now_ms;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.rad_load) begin
      rad_r  <= prod_r[31:0];
      root_r <= 32'd0;
    end else if (cmd.rad_add) begin
      rad_r <= rad_r + prod_r[31:0];
    end else if (cmd.root_step) begin
      if (fits) begin
        rad_r  <= rad_r - trial;
        root_r <= (root_r >> 1) + bit_val;
      end else begin
        root_r <= root_r >> 1;
      end
    end
    if (cmd.upd) begin
      dev_r <= dev;
      gap_r <= ((prev_r != 32'd0) && (now_r > prev_r)) ? (now_r - prev_r) : 32'd0;
    end
    if (cmd.report) begin
      o_cnt_r  <= cnt_r;
      o_act_r  <= act_r;
      o_peak_r <= peak_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 32'd0;
      act_r  <= 32'd0;
      peak_r <= 17'd0;
      prev_r <= 32'd0;
      rep_r  <= '0;
    end else begin
      if (cmd.upd) begin
        if (cnt_r != 32'hFFFF_FFFF) begin
          cnt_r <= cnt_r + 32'd1;
        end
        if (dev > peak_r) begin
          peak_r <= dev;
        end
        prev_r <= now_r;
      end
      if (cmd.acc && credit) begin
        act_r <= act_sum[32] ? 32'hFFFF_FFFF : act_sum[31:0];
      end
      if (cmd.report) begin
        rep_r <= secs;
      end
    end
  end

  assign out_total_samples  = o_cnt_r;
  assign out_active_time_ms = o_act_r;
  assign out_peak_deviation = o_peak_r;

  a_peak_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> peak_r >= $past(peak_r))
    else $error("peak deviation went down");

  a_active_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> act_r >= $past(act_r))
    else $error("active time went down");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> root_r[31:16] == 16'd0)
    else $error("square root out of range");

endmodule

FILE: hdl/atacc_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences squares, root steps, update, seconds check and snapshot handoff
// depends on atacc_pkg; commands atacc_dp

module atacc_ctrl import atacc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_SQZ  = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_ROOT = 4'd5;
  localparam logic [3:0] S_UPD  = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_CHK  = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              ovld_r, ovld_nxt;
  logic              out_free;

  assign out_free = !ovld_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.step  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SQX;
        end
      end
      S_SQX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQ_X;
        state_nxt   = S_SQY;
      end
      S_SQY: begin
        cmd.rad_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_SQ_Y;
        state_nxt    = S_SQZ;
      end
      S_SQZ: begin
        cmd.rad_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQ_Z;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.rad_add = 1'b1;
        step_nxt    = '0;
        state_nxt   = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DIV;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        // hold here only while a new beat is due and the snapshot register cannot take it yet
        if (!stat.emit) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          cmd.report = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (ovld_r && !out_stall) begin
      ovld_nxt = 1'b0;
    end
    if (cmd.report) begin
      ovld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  a_report_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |-> (!ovld_r || !out_stall))
    else $error("snapshot overwritten while a beat waits");

  a_root_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) && (step_r == STEP_LAST) |=> state_r == S_UPD)
    else $error("root iterations did not finish in order");

endmodule

FILE: hdl/activity_time_accumulator.sv
`timescale 1ns / 1ps
// top level of the activity time accumulator: register file, controller, datapath
// depends on atacc_pkg, atacc_regs, atacc_ctrl, atacc_dp
//
//  port group   direction  handshake                     payload
//  in_*         input      in_valid / in_stall           accel_x, accel_y, accel_z, now_ms
//  out_*        output     out_valid / out_stall         total_samples, active_time_ms,
//                                                        peak_deviation
//  apb          input      psel, penable, pwrite, pready move_threshold, max_gap_ms
//
// a sample passes through the accepting idle cycle, three squares on the
// shared multiplier, 16 square root steps, update, accumulate, divide by 1000 and check;
// a sample is taken only while idle, so a new one waits until the last is through.
// a snapshot waits in the output register; the controller holds in the check
// step only if a new snapshot is due while the previous one is still stalled.
// rst_n is synchronous: counters, peak, previous time and config defaults reset.

module activity_time_accumulator import atacc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic [31:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_total_samples,
  output logic [31:0]        out_active_time_ms,
  output logic [16:0]        out_peak_deviation,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  atacc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  atacc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  atacc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg),
    .in_accel_x         (in_accel_x),
    .in_accel_y         (in_accel_y),
    .in_accel_z         (in_accel_z),
    .in_now_ms          (in_now_ms),
    .stat               (stat),
    .out_total_samples  (out_total_samples),
    .out_active_time_ms (out_active_time_ms),
    .out_peak_deviation (out_peak_deviation)
  );

endmodule

FILE: tb/tb_activity_time_accumulator.sv
`timescale 1ns / 1ps
// self-checking bench for activity_time_accumulator: directed table, then random phases
// depends on atacc_pkg and the activity_time_accumulator rtl

module tb_activity_time_accumulator;
  import atacc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD = 400;
  localparam logic [ADDR_W-1:0] THR_ADDR = ADDR_W'({REG_MOVE_THR, 2'b00});
  localparam logic [ADDR_W-1:0] GAP_ADDR = ADDR_W'({REG_MAX_GAP, 2'b00});

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [31:0]        now;
  } sample_t;

  typedef struct packed {
    logic [31:0] total;
    logic [31:0] active;
    logic [16:0] peak;
  } snapshot_t;

  // known = 1 means the outcome is typed in here rather than predicted
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [31:0]        now;
    logic               known;
    logic               k_emit;
    logic [31:0]        k_total;
    logic [31:0]        k_active;
    logic [16:0]        k_peak;
  } dir_row_t;

  localparam int unsigned N_DIRECTED = 22;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{16'sd0, 16'sd0, 16'sd4096, 32'd0, 1'b1, 1'b1, 32'd1, 32'd0, 17'd0},
    '{16'sd0, 16'sd0, 16'sd0, 32'd100, 1'b1, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'h8000, 16'h8000, 16'h8000, 32'd300, 1'b1, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 32'd500, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd4096, 16'sd0, 16'sd0, 32'd700, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd8000, 16'sd0, 16'sd0, 32'd700, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd8000, 16'sd0, 16'sd0, 32'd650, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd8000, 16'sd0, 16'sd0, 32'd850, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd8000, 16'sd0, 16'sd0, 32'd1051, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd8000, 16'sd0, 16'sd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd8000, 16'sd0, 16'sd0, 32'd100, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd8000, 16'sd0, 16'sd0, 32'd300, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd8000, 16'sd0, 16'sd0, 32'd500, 1'b1, 1'b1, 32'd13, 32'd1000, 17'd52659},
    '{16'sd4506, 16'sd0, 16'sd0, 32'd600, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd4507, 16'sd0, 16'sd0, 32'd700, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd3686, 16'sd0, 16'sd0, 32'd800, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd3685, 16'sd0, 16'sd0, 32'd900, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{-16'sd1, 16'sd1, -16'sd4096, 32'hFFFF_FF40, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd8000, -16'sd8000, 16'sd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd0, 16'sd0, -16'sd4096, 32'h0000_0010, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'sd32767, 16'h8000, 16'sd12345, 32'h0000_00C8, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0},
    '{16'h8000, 16'sd0, 16'sd0, 32'h0000_0190, 1'b0, 1'b0, 32'd0, 32'd0, 17'd0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_y = '0;
  logic signed [15:0] in_accel_z = '0;
  logic [31:0]        in_now_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        out_total_samples;
  logic [31:0]        out_active_time_ms;
  logic [16:0]        out_peak_deviation;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  activity_time_accumulator i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_accel_x         (in_accel_x),
    .in_accel_y         (in_accel_y),
    .in_accel_z         (in_accel_z),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_total_samples  (out_total_samples),
    .out_active_time_ms (out_active_time_ms),
    .out_peak_deviation (out_peak_deviation),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // predicted block state and its copy of the registers
  logic [16:0] cfg_thr = THR_RESET;
  logic [15:0] cfg_gap = GAP_RESET;
  logic [31:0] seen_samples = '0;
  logic [31:0] active_ms = '0;
  logic [16:0] peak_dev = '0;
  logic [31:0] last_stamp = '0;
  logic [22:0] shown_secs = '0;

  snapshot_t   pending_snapshots [$];
  logic [31:0] stamp_ms = '0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned samples_sent = 0;
  int unsigned snapshots_due = 0;
  int unsigned snapshots_seen = 0;
  int unsigned mismatches = 0;
  int unsigned settings_used = 0;
  int unsigned cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic logic [15:0] floor_root(input logic [31:0] v);
    logic [15:0] r;
    logic [31:0] trial;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = 32'(r | (16'd1 << b));
      if (trial * trial <= v) r = r | (16'd1 << b);
    end
    return r;
  endfunction

  // one sample through the activity model; returns 1 when a snapshot is due
  function automatic bit advance_activity(input sample_t s, output snapshot_t snap);
    longint      ax, ay, az;
    logic [31:0] sum_sq, gap, secs;
    logic [15:0] mag;
    logic [16:0] dev;
    logic [32:0] widened;
    ax = s.x;
    ay = s.y;
    az = s.z;
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    if (az < 0) az = -az;
    sum_sq = 32'(ax * ax + ay * ay + az * az);
    mag = floor_root(sum_sq);
    dev = (17'(mag) >= ONE_G_COUNTS) ? 17'(mag) - ONE_G_COUNTS : ONE_G_COUNTS - 17'(mag);
    if (seen_samples != '1) seen_samples++;
    if (dev > peak_dev) peak_dev = dev;
    gap = (last_stamp != 0 && s.now > last_stamp) ? s.now - last_stamp : 32'd0;
    last_stamp = s.now;
    if (dev > cfg_thr && gap != 0 && gap <= 32'(cfg_gap)) begin
      widened = {1'b0, active_ms} + {1'b0, gap};
      active_ms = widened[32] ? '1 : widened[31:0];
    end
    secs = active_ms / 1000;
    snap = '{seen_samples, active_ms, peak_dev};
    if (secs != 32'(shown_secs) || seen_samples == 1) begin
      shown_secs = 23'(secs);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // mostly plausible motion with advancing time; some resets, rewinds and junk stamps
  function automatic sample_t make_random_sample();
    sample_t     s;
    int unsigned pick;
    int          lim, delta, zi;
    pick = $urandom_range(0, 19);
    if (pick < 14) stamp_ms += $urandom_range(1, (cfg_gap == 0) ? 1 : cfg_gap);
    else if (pick < 16) stamp_ms += 32'(cfg_gap) + $urandom_range(1, 64);
    else if (pick == 17) stamp_ms -= $urandom_range(1, 500);
    else if (pick == 18) stamp_ms = '0;
    else if (pick == 19) stamp_ms = $urandom;
    s.now = stamp_ms;
    case ($urandom_range(0, 3)) inside
      0, 1: begin
        s.x = 16'($urandom);
        s.y = 16'($urandom);
        s.z = 16'($urandom);
      end
      2: begin
        // straddle the movement threshold around 1 g
        lim = (int'(cfg_thr) + 3 > 20000) ? 20000 : int'(cfg_thr) + 3;
        delta = int'($urandom_range(0, 2 * lim)) - lim;
        zi = 4096 + delta;
        if ($urandom_range(0, 1) == 1) zi = -zi;
        s.x = 16'(int'($urandom_range(0, 64)) - 32);
        s.y = 16'(int'($urandom_range(0, 64)) - 32);
        s.z = 16'(zi);
      end
      default: begin
        zi = 4096 + int'($urandom_range(0, 16)) - 8;
        if ($urandom_range(0, 1) == 1) zi = -zi;
        s.x = 16'(int'($urandom_range(0, 16)) - 8);
        s.y = 16'(int'($urandom_range(0, 16)) - 8);
        s.z = 16'(zi);
      end
    endcase
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_accel_x <= s.x;
    in_accel_y <= s.y;
    in_accel_z <= s.z;
    in_now_ms <= s.now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic queue_snapshot(input snapshot_t snap);
    pending_snapshots.push_back(snap);
    snapshots_due++;
  endtask

  // drop valid, let every snapshot come out, then give a sample with no snapshot time to finish
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_thresholds(input logic [31:0] thr_word, input logic [31:0] gap_word);
    logic [31:0] rd;
    reg_access(1'b1, THR_ADDR, thr_word, rd);
    cfg_thr = thr_word[16:0];
    reg_access(1'b1, GAP_ADDR, gap_word, rd);
    cfg_gap = gap_word[15:0];
    reg_access(1'b0, THR_ADDR, '0, rd);
    if (rd[16:0] !== cfg_thr) begin
      mismatches++;
      $error("move_threshold readback: expected %0d, got %0d", cfg_thr, rd[16:0]);
    end
    reg_access(1'b0, GAP_ADDR, '0, rd);
    if (rd[15:0] !== cfg_gap) begin
      mismatches++;
      $error("max_gap_ms readback: expected %0d, got %0d", cfg_gap, rd[15:0]);
    end
    settings_used++;
  endtask

  task automatic run_phase(input logic [31:0] thr_word, input logic [31:0] gap_word,
                           input int unsigned count, input logic [31:0] first_stamp,
                           input bit with_hold, input int unsigned min_due);
    sample_t     s;
    snapshot_t   snap;
    int unsigned k;
    wait_drained();
    program_thresholds(thr_word, gap_word);
    stamp_ms = first_stamp;
    if (with_hold) hold_req = 1'b1;
    k = 0;
    while (k < count || (snapshots_due < min_due && k < 4 * count)) begin
      s = make_random_sample();
      send_sample(s);
      if (advance_activity(s, snap)) queue_snapshot(snap);
      // now and then the sender waits for the block to empty out
      if (k % 100 == 99) wait_drained();
      k++;
    end
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        hold_req = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_snapshots
    snapshot_t want;
    if (rst_n && out_valid && !out_stall) begin
      snapshots_seen++;
      if (pending_snapshots.size() == 0) begin
        mismatches++;
        $error("snapshot beat with none expected: total_samples %0d", out_total_samples);
      end else begin
        want = pending_snapshots.pop_front();
        if (out_total_samples !== want.total) begin
          mismatches++;
          $error("total_samples: expected %0d, got %0d", want.total, out_total_samples);
        end
        if (out_active_time_ms !== want.active) begin
          mismatches++;
          $error("active_time_ms: expected %0d, got %0d", want.active, out_active_time_ms);
        end
        if (out_peak_deviation !== want.peak) begin
          mismatches++;
          $error("peak_deviation: expected %0d, got %0d", want.peak, out_peak_deviation);
        end
      end
    end
  end

  initial begin
    dir_row_t  r;
    sample_t   s;
    snapshot_t snap;
    bit        emit;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows run on the reset values of the registers
    for (int i = 0; i < N_DIRECTED; i++) begin
      r = DIRECTED[i];
      s = '{r.x, r.y, r.z, r.now};
      send_sample(s);
      emit = advance_activity(s, snap);
      if (r.known) begin
        emit = r.k_emit;
        snap = '{r.k_total, r.k_active, r.k_peak};
      end
      if (emit) queue_snapshot(snap);
    end

    run_phase(32'($urandom_range(100, 2000)), 32'($urandom_range(50, 400)),
              300, 32'($urandom_range(1, 1000)), 1'b0, 0);
    // zero threshold and the widest gap limit: the output backs up under the long hold
    run_phase(32'd0, 32'd65535, 150, 32'd1, 1'b1, 0);
    // upper data bits set: both registers land at their maximum
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 80, 32'($urandom_range(1, 1000)), 1'b0, 0);
    run_phase(32'd0, 32'd0, 80, 32'($urandom_range(1, 1000)), 1'b0, 0);
    run_phase(32'($urandom_range(0, 4000)), 32'($urandom_range(1, 1000)),
              320, 32'hFFFF_F000, 1'b0, 0);
    idle_on = 1'b0;
    run_phase(32'd410, 32'd200, 250, 32'($urandom_range(1, 1000)), 1'b0, 48);
    wait_drained();

    $display("summary: %0d samples sent, %0d snapshots checked, %0d register settings",
             samples_sent, snapshots_seen, settings_used);
    $display("summary: %0d mismatches, %0d snapshots still pending",
             mismatches, pending_snapshots.size());
    if (mismatches == 0 && pending_snapshots.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
